FILE: hdl/gc_region_collection_set_selector_defines.svh
// Assertion macros shared by the collection set selector RTL.
`ifndef GC_REGION_COLLECTION_SET_SELECTOR_DEFINES_SVH
`define GC_REGION_COLLECTION_SET_SELECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GCRCSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GCRCSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/gcrcss_pkg.sv
// Types, constants and register codes of the collection set selector.
package gcrcss_pkg;

   localparam int BYTE_W = 48;
   localparam int CNT_W  = 16;
   localparam int AGE_W  = 4;
   localparam int TEN_W  = 5;
   localparam int IDX_W  = 4;
   // Shared adder width: covers byte counts times the percent scale.
   localparam int ALU_W  = 56;

   localparam logic [ALU_W-1:0] GARBAGE_PCT = ALU_W'(25);
   localparam logic [ALU_W-1:0] IGNORE_PCT  = ALU_W'(5);
   localparam logic [ALU_W-1:0] PCT_SCALE   = ALU_W'(100);

   localparam logic [BYTE_W-1:0] BYTE_MAX = '1;
   localparam logic [BYTE_W-1:0] REGION_BYTES_RST = BYTE_W'(4194304);
   localparam logic [TEN_W-1:0]  TENURE_AGE_RST   = TEN_W'(7);

   typedef enum logic [IDX_W-1:0] {
      CSR_YOUNG_BUDGET   = 4'd0,
      CSR_OLD_BUDGET     = 4'd1,
      CSR_SHARED_REGIONS = 4'd2,
      CSR_MIN_GARBAGE    = 4'd3,
      CSR_TENURE_AGE     = 4'd4,
      CSR_YOUNG_STEP     = 4'd5,
      CSR_OLD_STEP       = 4'd6,
      CSR_REGION_BYTES   = 4'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SOFT,
      ST_IGN,
      ST_GSUM,
      ST_MING,
      ST_NEED,
      ST_CHECK,
      ST_STEP,
      ST_SUM,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

   // carry: carry out of an add, or borrow (a < b) of a subtract
   typedef struct packed {
      logic [ALU_W-1:0] res;
      logic             carry;
   } alu_rsp_type;

endpackage

FILE: hdl/gc_region_collection_set_selector.sv
// Collection set selector: per-region candidate test, budget fit with reserve borrowing.
// The result register waits while the output is held; the next region is taken in the
// cycle after the result is registered. One region at a time: the threshold, minimum and
// limit compares and the byte sums run through the single shared 56-bit adder, and each
// reserve region borrowed costs a compare and an add.
// Reset: totals, usage and borrow count clear, config registers take their defaults.
module gc_region_collection_set_selector (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [gcrcss_pkg::BYTE_W-1:0]          req_garbage_bytes,
   input  logic [gcrcss_pkg::BYTE_W-1:0]          req_live_bytes,
   input  logic                                   req_is_old_region,
   input  logic [gcrcss_pkg::AGE_W-1:0]           req_region_age,
   input  logic                                   req_last_region,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_added,
   output logic [gcrcss_pkg::BYTE_W-1:0]          rsp_young_evac_total,
   output logic [gcrcss_pkg::BYTE_W-1:0]          rsp_old_evac_total,
   output logic [gcrcss_pkg::BYTE_W-1:0]          rsp_promo_total,
   output logic [gcrcss_pkg::BYTE_W-1:0]          rsp_garbage_total,
   output logic                                   rsp_done_res,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gcrcss_pkg::IDX_W-1:0]           csr_index,
   input  logic [gcrcss_pkg::BYTE_W-1:0]          csr_wdata
);
   import gcrcss_pkg::*;

   `include "gc_region_collection_set_selector_defines.svh"

   function automatic logic [BYTE_W-1:0] sat_bytes(input logic [ALU_W-1:0] v);
      logic [BYTE_W-1:0] r;
      r = (|v[ALU_W-1:BYTE_W]) ? BYTE_MAX : v[BYTE_W-1:0];
      return r;
   endfunction

   // configuration
   logic [BYTE_W-1:0] young_budget_ff, old_budget_ff, min_garbage_ff;
   logic [BYTE_W-1:0] young_step_ff, old_step_ff, region_bytes_ff;
   logic [CNT_W-1:0]  shared_regions_ff;
   logic [TEN_W-1:0]  tenure_age_ff;

   // batch state
   logic [BYTE_W-1:0] garbage_sum_ff, young_used_ff, old_used_ff;
   logic [BYTE_W-1:0] young_limit_ff, old_limit_ff;
   logic [BYTE_W-1:0] young_evac_ff, old_evac_ff, promo_ff;
   logic [CNT_W-1:0]  borrowed_ff;
   logic              batch_open_ff;

   // current region
   logic [BYTE_W-1:0] garbage_ff, live_ff;
   logic              is_old_ff, last_ff, tenured_ff;
   logic [AGE_W-1:0]  age_ff;
   logic [ALU_W-1:0]  g100_ff, soft_ff, ign_ff;
   logic              soft_hit_ff, ign_hit_ff, added_ff;
   logic [BYTE_W:0]   new_garbage_ff, need_ff;
   logic [BYTE_W-1:0] lim_ff;
   logic [CNT_W-1:0]  taken_ff;

   // result register
   logic              rsp_valid_ff, rsp_added_ff, rsp_done_ff;
   logic [BYTE_W-1:0] rsp_young_ff, rsp_old_ff, rsp_promo_ff, rsp_garbage_ff;

   seq_state_type state_ff, state_in;
   alu_req_type   alu_req;
   alu_rsp_type   alu_rsp;

   logic              req_fire, out_free, commit_ok;
   logic [BYTE_W-1:0] used_sel, limit_sel, step_sel, evac_sel;

   gcrcss_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign used_sel  = tenured_ff ? old_used_ff  : young_used_ff;
   assign limit_sel = tenured_ff ? old_limit_ff : young_limit_ff;
   assign step_sel  = tenured_ff ? old_step_ff  : young_step_ff;
   assign evac_sel  = !tenured_ff ? young_evac_ff : (is_old_ff ? old_evac_ff : promo_ff);
   assign commit_ok = (taken_ff < shared_regions_ff) && (step_sel != '0);

   always_comb begin
      state_in    = state_ff;
      alu_req.a   = '0;
      alu_req.b   = '0;
      alu_req.sub = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_SOFT;
         end
         ST_SOFT: begin
            // soft threshold hit when region_bytes * pct < garbage * 100
            alu_req.a   = soft_ff;
            alu_req.b   = g100_ff;
            alu_req.sub = 1'b1;
            state_in    = ST_IGN;
         end
         ST_IGN: begin
            alu_req.a   = ign_ff;
            alu_req.b   = g100_ff;
            alu_req.sub = 1'b1;
            state_in    = ST_GSUM;
         end
         ST_GSUM: begin
            alu_req.a = ALU_W'(garbage_sum_ff);
            alu_req.b = ALU_W'(garbage_ff);
            state_in  = ST_MING;
         end
         ST_MING: begin
            alu_req.a   = ALU_W'(new_garbage_ff);
            alu_req.b   = ALU_W'(min_garbage_ff);
            alu_req.sub = 1'b1;
            if (soft_hit_ff || (ign_hit_ff && alu_rsp.carry)) state_in = ST_NEED;
            else state_in = ST_DONE;
         end
         ST_NEED: begin
            alu_req.a = ALU_W'(used_sel);
            alu_req.b = ALU_W'(live_ff);
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            // borrow means need exceeds the limit
            alu_req.a   = ALU_W'(lim_ff);
            alu_req.b   = ALU_W'(need_ff);
            alu_req.sub = 1'b1;
            if (!alu_rsp.carry) state_in = ST_SUM;
            else if (commit_ok) state_in = ST_STEP;
            else state_in = ST_DONE;
         end
         ST_STEP: begin
            alu_req.a = ALU_W'(lim_ff);
            alu_req.b = ALU_W'(step_sel);
            state_in  = ST_CHECK;
         end
         ST_SUM: begin
            alu_req.a = ALU_W'(evac_sel);
            alu_req.b = ALU_W'(live_ff);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and batch state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         batch_open_ff     <= 1'b0;
         young_budget_ff   <= '0;
         old_budget_ff     <= '0;
         shared_regions_ff <= '0;
         min_garbage_ff    <= '0;
         tenure_age_ff     <= TENURE_AGE_RST;
         young_step_ff     <= '0;
         old_step_ff       <= '0;
         region_bytes_ff   <= REGION_BYTES_RST;
         garbage_sum_ff    <= '0;
         young_used_ff     <= '0;
         old_used_ff       <= '0;
         young_limit_ff    <= '0;
         old_limit_ff      <= '0;
         borrowed_ff       <= '0;
         young_evac_ff     <= '0;
         old_evac_ff       <= '0;
         promo_ff          <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_YOUNG_BUDGET:   young_budget_ff   <= csr_wdata;
               CSR_OLD_BUDGET:     old_budget_ff     <= csr_wdata;
               CSR_SHARED_REGIONS: shared_regions_ff <= csr_wdata[CNT_W-1:0];
               CSR_MIN_GARBAGE:    min_garbage_ff    <= csr_wdata;
               CSR_TENURE_AGE:     tenure_age_ff     <= csr_wdata[TEN_W-1:0];
               CSR_YOUNG_STEP:     young_step_ff     <= csr_wdata;
               CSR_OLD_STEP:       old_step_ff       <= csr_wdata;
               CSR_REGION_BYTES:   region_bytes_ff   <= csr_wdata;
               default: ;
            endcase
         end

         // first region of a batch reloads the budgets
         if (req_fire && !batch_open_ff) begin
            young_limit_ff <= young_budget_ff;
            old_limit_ff   <= old_budget_ff;
            borrowed_ff    <= '0;
         end
         if (req_fire) batch_open_ff <= 1'b1;

         if (state_ff == ST_SUM) begin
            borrowed_ff    <= taken_ff;
            garbage_sum_ff <= new_garbage_ff[BYTE_W] ? BYTE_MAX : new_garbage_ff[BYTE_W-1:0];
            if (tenured_ff) begin
               old_limit_ff <= lim_ff;
               old_used_ff  <= need_ff[BYTE_W-1:0];
               if (is_old_ff) old_evac_ff <= sat_bytes(alu_rsp.res);
               else promo_ff <= sat_bytes(alu_rsp.res);
            end else begin
               young_limit_ff <= lim_ff;
               young_used_ff  <= need_ff[BYTE_W-1:0];
               young_evac_ff  <= sat_bytes(alu_rsp.res);
            end
         end

         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
            // drop the batch after its last region is reported
            if (last_ff) begin
               batch_open_ff  <= 1'b0;
               garbage_sum_ff <= '0;
               young_used_ff  <= '0;
               old_used_ff    <= '0;
               borrowed_ff    <= '0;
               young_evac_ff  <= '0;
               old_evac_ff    <= '0;
               promo_ff       <= '0;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath of the current region and the result register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         garbage_ff <= req_garbage_bytes;
         live_ff    <= req_live_bytes;
         is_old_ff  <= req_is_old_region;
         age_ff     <= req_region_age;
         last_ff    <= req_last_region;
         added_ff   <= 1'b0;
      end
      case (state_ff)
         ST_MUL: begin
            g100_ff    <= ALU_W'(garbage_ff) * PCT_SCALE;
            soft_ff    <= ALU_W'(region_bytes_ff) * GARBAGE_PCT;
            ign_ff     <= ALU_W'(region_bytes_ff) * IGNORE_PCT;
            tenured_ff <= is_old_ff || ({1'b0, age_ff} >= tenure_age_ff);
         end
         ST_SOFT: soft_hit_ff <= alu_rsp.carry;
         ST_IGN:  ign_hit_ff  <= alu_rsp.carry;
         ST_GSUM: new_garbage_ff <= alu_rsp.res[BYTE_W:0];
         ST_NEED: begin
            need_ff  <= alu_rsp.res[BYTE_W:0];
            lim_ff   <= limit_sel;
            taken_ff <= borrowed_ff;
         end
         ST_STEP: begin
            lim_ff   <= sat_bytes(alu_rsp.res);
            taken_ff <= taken_ff + CNT_W'(1);
         end
         ST_SUM: added_ff <= 1'b1;
         ST_DONE: begin
            if (out_free) begin
               rsp_added_ff   <= added_ff;
               rsp_young_ff   <= young_evac_ff;
               rsp_old_ff     <= old_evac_ff;
               rsp_promo_ff   <= promo_ff;
               rsp_garbage_ff <= garbage_sum_ff;
               rsp_done_ff    <= last_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_added            = rsp_added_ff;
   assign rsp_young_evac_total = rsp_young_ff;
   assign rsp_old_evac_total   = rsp_old_ff;
   assign rsp_promo_total      = rsp_promo_ff;
   assign rsp_garbage_total    = rsp_garbage_ff;
   assign rsp_done_res         = rsp_done_ff;

   `GCRCSS_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == ST_MUL, "accepted beat did not start the sequence")
   `GCRCSS_ASSERT_NOW(a_young_fits, clock, reset, batch_open_ff, young_used_ff <= young_limit_ff, "young usage above limit")
   `GCRCSS_ASSERT_NOW(a_old_fits, clock, reset, batch_open_ff, old_used_ff <= old_limit_ff, "old usage above limit")
   `GCRCSS_ASSERT_NOW(a_borrow_bounded, clock, reset, state_ff == ST_STEP, taken_ff < shared_regions_ff, "borrow past reserve count")
   `GCRCSS_ASSERT_NEXT(a_commit_adds, clock, reset, state_ff == ST_SUM, (state_ff == ST_DONE) && added_ff, "commit did not mark region added")

endmodule

FILE: hdl/gcrcss_alu.sv
// Shared add/subtract unit used by the selector sequencer for its byte sums and byte compares.
module gcrcss_alu (
   input  gcrcss_pkg::alu_req_type alu_req,
   output gcrcss_pkg::alu_rsp_type alu_rsp
);
   import gcrcss_pkg::*;

   logic [ALU_W:0] sum;

   // Subtract as a + ~b + 1; the top bit is then the borrow.
   assign sum = {1'b0, alu_req.a}
              + ({1'b0, alu_req.b} ^ {(ALU_W+1){alu_req.sub}})
              + {{ALU_W{1'b0}}, alu_req.sub};

   assign alu_rsp.res   = sum[ALU_W-1:0];
   assign alu_rsp.carry = sum[ALU_W];

endmodule

FILE: tb/sv/gc_region_collection_set_selector_test.sv
// Self-checking testbench for the collection set selector: directed plan, then random batches.
module gc_region_collection_set_selector_test;
   import gcrcss_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 10;
   localparam longint LIMIT_CYCLES = 4000000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_REGIONS = 140;
   localparam int PRESSURE_PHASE = 4;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [IDX_W-1:0] CSR_NO_REGISTER = 4'd13;
   localparam logic [BYTE_W-1:0] FULL = BYTE_MAX;

   typedef struct packed {
      logic [BYTE_W-1:0] garbage;
      logic [BYTE_W-1:0] live;
      logic              is_old;
      logic [AGE_W-1:0]  age;
      logic              last;
   } region_type;

   typedef struct packed {
      logic              added;
      logic [BYTE_W-1:0] young_evac;
      logic [BYTE_W-1:0] old_evac;
      logic [BYTE_W-1:0] promo;
      logic [BYTE_W-1:0] garbage;
      logic              done;
   } verdict_type;

   typedef struct {
      logic              is_reg;
      logic [IDX_W-1:0]  reg_index;
      logic [BYTE_W-1:0] reg_data;
      region_type        region;
      logic              typed;
      verdict_type       want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [BYTE_W-1:0] req_garbage_bytes = '0;
   logic [BYTE_W-1:0] req_live_bytes = '0;
   logic req_is_old_region = 1'b0;
   logic [AGE_W-1:0] req_region_age = '0;
   logic req_last_region = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_added;
   logic [BYTE_W-1:0] rsp_young_evac_total;
   logic [BYTE_W-1:0] rsp_old_evac_total;
   logic [BYTE_W-1:0] rsp_promo_total;
   logic [BYTE_W-1:0] rsp_garbage_total;
   logic rsp_done_res;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0] csr_wdata = '0;

   gc_region_collection_set_selector dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_garbage_bytes(req_garbage_bytes),
      .req_live_bytes(req_live_bytes),
      .req_is_old_region(req_is_old_region),
      .req_region_age(req_region_age),
      .req_last_region(req_last_region),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_added(rsp_added),
      .rsp_young_evac_total(rsp_young_evac_total),
      .rsp_old_evac_total(rsp_old_evac_total),
      .rsp_promo_total(rsp_promo_total),
      .rsp_garbage_total(rsp_garbage_total),
      .rsp_done_res(rsp_done_res),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Register copies and selection state mirrored by the predictor.
   logic [BYTE_W-1:0] cfg_young_budget = '0;
   logic [BYTE_W-1:0] cfg_old_budget = '0;
   logic [CNT_W-1:0]  cfg_shared_regions = '0;
   logic [BYTE_W-1:0] cfg_min_garbage = '0;
   logic [TEN_W-1:0]  cfg_tenure_age = TENURE_AGE_RST;
   logic [BYTE_W-1:0] cfg_young_step = '0;
   logic [BYTE_W-1:0] cfg_old_step = '0;
   logic [BYTE_W-1:0] cfg_region_bytes = REGION_BYTES_RST;

   logic [BYTE_W-1:0] garbage_acc = '0;
   logic [BYTE_W-1:0] young_charged = '0;
   logic [BYTE_W-1:0] old_charged = '0;
   logic [BYTE_W-1:0] young_cap = '0;
   logic [BYTE_W-1:0] old_cap = '0;
   logic [CNT_W-1:0]  reserve_taken = '0;
   logic [BYTE_W-1:0] young_live_acc = '0;
   logic [BYTE_W-1:0] old_live_acc = '0;
   logic [BYTE_W-1:0] promo_live_acc = '0;
   logic              batch_active = 1'b0;

   verdict_type pending_verdicts[$];
   verdict_type arrived;
   plan_row_type plan[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int hold_granted = 0;
   int hold_left = 0;
   int live_scale = 1000;
   int error_count = 0;
   int regions_sent = 0;
   int batches_sent = 0;
   int regions_added = 0;
   int verdicts_seen = 0;
   longint cycles = 0;

   function automatic logic [BYTE_W-1:0] clamp48(input logic [BYTE_W:0] v);
      return v[BYTE_W] ? FULL : v[BYTE_W-1:0];
   endfunction

   function automatic logic [BYTE_W-1:0] rand48();
      return BYTE_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [ALU_W-1:0] pct_of_region(input logic [ALU_W-1:0] pct);
      return ({{(ALU_W-BYTE_W){1'b0}}, cfg_region_bytes} * pct) / PCT_SCALE;
   endfunction

   // Borrow reserve regions until need fits; leave the borrow count alone on failure.
   function automatic logic fit_with_reserve(input logic [BYTE_W:0] need,
                                             input logic [BYTE_W-1:0] cap_in,
                                             input logic [BYTE_W-1:0] step,
                                             output logic [BYTE_W-1:0] cap_out);
      logic [BYTE_W-1:0] lim;
      logic [CNT_W-1:0] taken;
      lim = cap_in;
      taken = reserve_taken;
      cap_out = cap_in;
      while ((need > {1'b0, lim}) && (taken < cfg_shared_regions)) begin
         taken = taken + 1'b1;
         lim = clamp48({1'b0, lim} + {1'b0, step});
      end
      if (need <= {1'b0, lim}) begin
         cap_out = lim;
         reserve_taken = taken;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic verdict_type select_region(input region_type r);
      logic [ALU_W-1:0] soft_cut;
      logic [ALU_W-1:0] ignore_cut;
      logic [BYTE_W:0] garbage_next;
      logic [BYTE_W:0] need;
      logic [BYTE_W-1:0] cap_next;
      logic regardless;
      logic candidate;
      logic tenured;
      logic fits;
      verdict_type v;
      soft_cut = pct_of_region(GARBAGE_PCT);
      ignore_cut = pct_of_region(IGNORE_PCT);
      if (!batch_active) begin
         young_cap = cfg_young_budget;
         old_cap = cfg_old_budget;
         reserve_taken = '0;
         batch_active = 1'b1;
      end
      garbage_next = {1'b0, garbage_acc} + {1'b0, r.garbage};
      regardless = (ALU_W'(r.garbage) > ignore_cut) && (garbage_next < {1'b0, cfg_min_garbage});
      candidate = regardless || (ALU_W'(r.garbage) > soft_cut);
      tenured = r.is_old || ({1'b0, r.age} >= cfg_tenure_age);
      fits = 1'b0;
      if (candidate) begin
         if (tenured) begin
            need = {1'b0, old_charged} + {1'b0, r.live};
            fits = fit_with_reserve(need, old_cap, cfg_old_step, cap_next);
            old_cap = cap_next;
            if (fits) begin
               old_charged = need[BYTE_W-1:0];
               if (r.is_old)
                  old_live_acc = clamp48({1'b0, old_live_acc} + {1'b0, r.live});
               else
                  promo_live_acc = clamp48({1'b0, promo_live_acc} + {1'b0, r.live});
            end
         end else begin
            need = {1'b0, young_charged} + {1'b0, r.live};
            fits = fit_with_reserve(need, young_cap, cfg_young_step, cap_next);
            young_cap = cap_next;
            if (fits) begin
               young_charged = need[BYTE_W-1:0];
               young_live_acc = clamp48({1'b0, young_live_acc} + {1'b0, r.live});
            end
         end
         if (fits)
            garbage_acc = clamp48(garbage_next);
      end
      v.added = fits;
      v.young_evac = young_live_acc;
      v.old_evac = old_live_acc;
      v.promo = promo_live_acc;
      v.garbage = garbage_acc;
      v.done = r.last;
      // Close the batch: totals are reported first, then cleared.
      if (r.last) begin
         garbage_acc = '0;
         young_charged = '0;
         old_charged = '0;
         young_cap = cfg_young_budget;
         old_cap = cfg_old_budget;
         reserve_taken = '0;
         young_live_acc = '0;
         old_live_acc = '0;
         promo_live_acc = '0;
         batch_active = 1'b0;
      end
      return v;
   endfunction

   function automatic region_type draw_region(input logic last);
      logic [ALU_W-1:0] soft_cut;
      logic [ALU_W-1:0] ignore_cut;
      region_type r;
      soft_cut = pct_of_region(GARBAGE_PCT);
      ignore_cut = pct_of_region(IGNORE_PCT);
      case ($urandom_range(0, 9))
         0: r.garbage = '0;
         1: r.garbage = BYTE_W'(ignore_cut + ALU_W'($urandom_range(0, 2)) - 1);
         2: r.garbage = BYTE_W'(soft_cut + ALU_W'($urandom_range(0, 2)) - 1);
         3: r.garbage = rand48();
         4: r.garbage = BYTE_W'($urandom_range(0, 1000));
         default: r.garbage = BYTE_W'(soft_cut + ALU_W'($urandom_range(1, 1000)));
      endcase
      case ($urandom_range(0, 9))
         0: r.live = '0;
         1: r.live = rand48();
         2: r.live = FULL;
         default: r.live = BYTE_W'($urandom_range(0, live_scale));
      endcase
      r.is_old = ($urandom_range(0, 2) == 0);
      r.age = AGE_W'($urandom_range(0, 15));
      r.last = last;
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] draw_budget();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return rand48();
         default: return BYTE_W'(live_scale * $urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] draw_step();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return FULL;
         2: return rand48();
         default: return BYTE_W'($urandom_range(1, 2 * live_scale));
      endcase
   endfunction

   function automatic plan_row_type reg_row(input logic [IDX_W-1:0] idx,
                                            input logic [BYTE_W-1:0] data);
      plan_row_type p;
      p.is_reg = 1'b1;
      p.reg_index = idx;
      p.reg_data = data;
      p.region = '0;
      p.typed = 1'b0;
      p.want = '0;
      return p;
   endfunction

   function automatic plan_row_type region_row(input logic [BYTE_W-1:0] garbage,
                                               input logic [BYTE_W-1:0] live,
                                               input logic is_old,
                                               input logic [AGE_W-1:0] age,
                                               input logic last);
      plan_row_type p;
      p.is_reg = 1'b0;
      p.reg_index = '0;
      p.reg_data = '0;
      p.region = '{garbage, live, is_old, age, last};
      p.typed = 1'b0;
      p.want = '0;
      return p;
   endfunction

   // Rows right after reset: evacuation totals stay zero, only garbage moves.
   function automatic plan_row_type known_row(input logic [BYTE_W-1:0] garbage,
                                              input logic [BYTE_W-1:0] live,
                                              input logic is_old,
                                              input logic [AGE_W-1:0] age,
                                              input logic last,
                                              input logic added,
                                              input logic [BYTE_W-1:0] garbage_total);
      plan_row_type p;
      p = region_row(garbage, live, is_old, age, last);
      p.typed = 1'b1;
      p.want = '{added, '0, '0, '0, garbage_total, last};
      return p;
   endfunction

   task automatic program_reg(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_YOUNG_BUDGET:   cfg_young_budget = data;
         CSR_OLD_BUDGET:     cfg_old_budget = data;
         CSR_SHARED_REGIONS: cfg_shared_regions = data[CNT_W-1:0];
         CSR_MIN_GARBAGE:    cfg_min_garbage = data;
         CSR_TENURE_AGE:     cfg_tenure_age = data[TEN_W-1:0];
         CSR_YOUNG_STEP:     cfg_young_step = data;
         CSR_OLD_STEP:       cfg_old_step = data;
         CSR_REGION_BYTES:   cfg_region_bytes = data;
         default: ;
      endcase
   endtask

   task automatic offer_region(input region_type r, input logic typed, input verdict_type want);
      verdict_type guess;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_garbage_bytes <= r.garbage;
      req_live_bytes <= r.live;
      req_is_old_region <= r.is_old;
      req_region_age <= r.age;
      req_last_region <= r.last;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      guess = select_region(r);
      pending_verdicts.push_back(typed ? want : guess);
      regions_sent++;
      if (r.last)
         batches_sent++;
   endtask

   // Drop valid, wait for every pending verdict, then let the block settle.
   task automatic await_idle();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [BYTE_W-1:0] want,
                                input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_request != hold_granted) begin
         hold_granted = hold_request;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         verdicts_seen++;
         if (rsp_added === 1'b1)
            regions_added++;
         if (pending_verdicts.size() == 0) begin
            $error("result beat with no region pending");
            error_count++;
         end else begin
            arrived = pending_verdicts.pop_front();
            compare_field("added", BYTE_W'(arrived.added), BYTE_W'(rsp_added));
            compare_field("young_evac_total", arrived.young_evac, rsp_young_evac_total);
            compare_field("old_evac_total", arrived.old_evac, rsp_old_evac_total);
            compare_field("promo_total", arrived.promo, rsp_promo_total);
            compare_field("garbage_total", arrived.garbage, rsp_garbage_total);
            compare_field("done_res", BYTE_W'(arrived.done), BYTE_W'(rsp_done_res));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("gc_region_collection_set_selector_test: done, errors");
         $finish;
      end
   end

   initial begin
      int phase;
      int n;
      int batch_left;
      logic [BYTE_W-1:0] rb;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: zero budgets, no reserve, soft cut 1048576.
      plan.push_back(known_row('0, '0, 1'b0, 4'd0, 1'b0, 1'b0, '0));
      plan.push_back(known_row(48'd1048577, '0, 1'b0, 4'd0, 1'b0, 1'b1, 48'd1048577));
      plan.push_back(known_row(48'd1048576, '0, 1'b0, 4'd0, 1'b0, 1'b0, 48'd1048577));
      plan.push_back(known_row(FULL, FULL, 1'b1, 4'd0, 1'b0, 1'b0, 48'd1048577));
      plan.push_back(known_row(FULL, '0, 1'b1, 4'd0, 1'b0, 1'b1, FULL));
      plan.push_back(known_row(FULL, '0, 1'b0, 4'd15, 1'b1, 1'b1, FULL));
      // Zero region size, zero old step, tenure age that never tenures.
      plan.push_back(reg_row(CSR_YOUNG_BUDGET, 48'd1000));
      plan.push_back(reg_row(CSR_OLD_BUDGET, 48'd500));
      plan.push_back(reg_row(CSR_SHARED_REGIONS, 48'd3));
      plan.push_back(reg_row(CSR_YOUNG_STEP, 48'd100));
      plan.push_back(reg_row(CSR_OLD_STEP, '0));
      plan.push_back(reg_row(CSR_REGION_BYTES, '0));
      plan.push_back(reg_row(CSR_MIN_GARBAGE, 48'd50));
      plan.push_back(reg_row(CSR_TENURE_AGE, 48'd16));
      plan.push_back(region_row(48'd3, 48'd600, 1'b1, 4'd0, 1'b0));
      plan.push_back(region_row(48'd1, 48'd1000, 1'b0, 4'd15, 1'b0));
      plan.push_back(region_row('0, 48'd5, 1'b0, 4'd3, 1'b0));
      plan.push_back(region_row(48'd2, 48'd250, 1'b0, 4'd9, 1'b0));
      plan.push_back(region_row(48'd4, 48'd100, 1'b0, 4'd1, 1'b0));
      plan.push_back(region_row(48'd5, 48'd500, 1'b1, 4'd2, 1'b1));
      // Full-size region, saturating old step, everything tenured.
      plan.push_back(reg_row(CSR_TENURE_AGE, '0));
      plan.push_back(reg_row(CSR_OLD_BUDGET, 48'd10));
      plan.push_back(reg_row(CSR_OLD_STEP, FULL));
      plan.push_back(reg_row(CSR_SHARED_REGIONS, 48'd2));
      plan.push_back(reg_row(CSR_REGION_BYTES, FULL));
      plan.push_back(reg_row(CSR_MIN_GARBAGE, FULL));
      plan.push_back(region_row(48'd14073748835533, 48'd20, 1'b0, 4'd0, 1'b0));
      plan.push_back(region_row(48'd14073748835532, '0, 1'b0, 4'd0, 1'b0));
      plan.push_back(region_row(FULL, FULL - 48'd20, 1'b1, 4'd7, 1'b1));
      // Borrow the whole reserve one region at a time.
      plan.push_back(reg_row(CSR_NO_REGISTER, FULL));
      plan.push_back(reg_row(CSR_YOUNG_BUDGET, '0));
      plan.push_back(reg_row(CSR_YOUNG_STEP, 48'd1));
      plan.push_back(reg_row(CSR_SHARED_REGIONS, 48'd65535));
      plan.push_back(reg_row(CSR_REGION_BYTES, 48'd4));
      plan.push_back(reg_row(CSR_TENURE_AGE, 48'd15));
      plan.push_back(reg_row(CSR_MIN_GARBAGE, '0));
      plan.push_back(region_row(48'd2, '0, 1'b0, 4'd15, 1'b0));
      plan.push_back(region_row(48'd2, 48'd65535, 1'b0, 4'd14, 1'b1));

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            if (!csr_valid)
               await_idle();
            program_reg(plan[i].reg_index, plan[i].reg_data);
         end else begin
            if (csr_valid)
               csr_valid <= 1'b0;
            offer_region(plan[i].region, plan[i].typed, plan[i].want);
         end
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         await_idle();
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 79; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 79; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
         endcase
         live_scale = $urandom_range(10, 5000);
         case ($urandom_range(0, 7))
            0: rb = '0;
            1: rb = 48'd1;
            2: rb = rand48();
            3: rb = REGION_BYTES_RST;
            default: rb = BYTE_W'($urandom_range(100, 40000));
         endcase
         program_reg(CSR_REGION_BYTES, rb);
         program_reg(CSR_YOUNG_BUDGET, draw_budget());
         program_reg(CSR_OLD_BUDGET, draw_budget());
         program_reg(CSR_YOUNG_STEP, draw_step());
         program_reg(CSR_OLD_STEP, draw_step());
         program_reg(CSR_SHARED_REGIONS,
                     ($urandom_range(0, 7) == 0) ? 48'd64 : BYTE_W'($urandom_range(0, 20)));
         program_reg(CSR_TENURE_AGE, BYTE_W'($urandom_range(0, 16)));
         case ($urandom_range(0, 5))
            0: program_reg(CSR_MIN_GARBAGE, '0);
            1: program_reg(CSR_MIN_GARBAGE, rand48());
            2: program_reg(CSR_MIN_GARBAGE, FULL);
            default: program_reg(CSR_MIN_GARBAGE, (rb >> 2) * BYTE_W'($urandom_range(0, 8)));
         endcase
         program_reg(CSR_NO_REGISTER, rand48());
         csr_valid <= 1'b0;

         batch_left = 0;
         for (n = 0; n < PHASE_REGIONS; n++) begin
            if (batch_left == 0)
               batch_left = $urandom_range(1, 16);
            batch_left--;
            if (n == PHASE_REGIONS - 1)
               batch_left = 0;
            // Pause until drained, then hold the receiver while regions keep coming.
            if (phase == PRESSURE_PHASE && n == PHASE_REGIONS / 2) begin
               await_idle();
               hold_request++;
            end
            offer_region(draw_region(batch_left == 0), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      stall_pct = 0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d regions in %0d batches, %0d joined the set, %0d result beats checked",
               regions_sent, batches_sent, regions_added, verdicts_seen);
      $display("covered threshold edges, zero step, saturation, full reserve borrow, long hold");
      if (error_count == 0)
         $display("gc_region_collection_set_selector_test: done, clean");
      else
         $display("gc_region_collection_set_selector_test: done, errors");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/gcrcss_pkg.sv
hdl/gcrcss_alu.sv
hdl/gc_region_collection_set_selector.sv
tb/sv/gc_region_collection_set_selector_test.sv
